// ===== rtl/ordered_list_insert_delete_engine_unit_assert.svh =====
// Assertion macros shared by the checker files.
// Each macro samples on the rising edge of clk and is quiet while rst_n is low.
`ifndef ORDERED_LIST_INSERT_DELETE_ENGINE_UNIT_ASSERT_SVH
`define ORDERED_LIST_INSERT_DELETE_ENGINE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OLIDE_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("olide assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define OLIDE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("olide assertion failed");

`endif

// ===== rtl/olide_pkg.sv =====
package olide_pkg;

    // Default list capacity.
    localparam int CAPACITY_DEF = 32;

    // Fixed field widths.
    localparam int MODE_W  = 3;
    localparam int DATA_W  = 32;
    localparam int POS_W   = 6;
    localparam int STAT_W  = 2;
    localparam int LEN_W   = 6;

    // Compare width that covers every count and position up to a capacity of 64.
    localparam int CTL_W   = 7;

    typedef enum logic [MODE_W-1:0] {
        MODE_INS_FRONT = 3'd0,
        MODE_INS_END   = 3'd1,
        MODE_INS_AT    = 3'd2,
        MODE_DEL_FRONT = 3'd3,
        MODE_DEL_END   = 3'd4,
        MODE_DEL_AT    = 3'd5,
        MODE_DUMP      = 3'd6
    } mode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_FULL  = 2'd3
    } status_t;

    // The operation broadcast to every cell of the chain.
    typedef enum logic [1:0] {
        CELL_HOLD = 2'd0,
        CELL_INS  = 2'd1,
        CELL_DEL  = 2'd2,
        CELL_ROT  = 2'd3
    } cell_op_t;

    // Broadcast control from the sequencer to the cells.
    typedef struct packed {
        cell_op_t           op;
        logic [CTL_W-1:0]   pos;
        logic [CTL_W-1:0]   tail;
        logic [DATA_W-1:0]  value;
        logic [DATA_W-1:0]  head;
    } cell_ctl_t;

endpackage

// ===== rtl/olide_cell.sv =====
module olide_cell
    import olide_pkg::*;
#(
    parameter int IDX = 0
)
(
    input  logic              clk,
    input  cell_ctl_t         ctl,
    input  logic [DATA_W-1:0] left_data,
    input  logic [DATA_W-1:0] right_data,
    output logic [DATA_W-1:0] data
);

    localparam logic [CTL_W-1:0] MY_IDX = CTL_W'(IDX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    // Each cell decides from its own index whether it shifts, loads or holds.
    always_comb
    begin
        data_next = data_reg;
        case (ctl.op)
            CELL_INS:
            begin
                if (MY_IDX > ctl.pos)
                begin
                    data_next = left_data;
                end
                else if (MY_IDX == ctl.pos)
                begin
                    data_next = ctl.value;
                end
            end
            CELL_DEL:
            begin
                if (MY_IDX >= ctl.pos)
                begin
                    data_next = right_data;
                end
            end
            CELL_ROT:
            begin
                if (MY_IDX < ctl.tail)
                begin
                    data_next = right_data;
                end
                else if (MY_IDX == ctl.tail)
                begin
                    data_next = ctl.head;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// ===== rtl/ordered_list_insert_delete_engine_unit.sv =====
// Every operation but dump delivers its one result in the cycle after it is accepted.
// Throughput: one non-dump request per cycle while in_stall is low; the whole chain of cells shifts at once.
// A dump of N entries gives N results, one entry each, and stalls the input meanwhile.
// Reset (rst_n low, asynchronous) empties the list and clears the output valid;
// cell contents are not reset and are only read below the entry count.
module ordered_list_insert_delete_engine_unit
    import olide_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [MODE_W-1:0]   mode,
    input  logic signed [DATA_W-1:0] value,
    input  logic [POS_W-1:0]    position,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STAT_W-1:0]   status,
    output logic signed [DATA_W-1:0] element,
    output logic [LEN_W-1:0]    length,
    output logic                last
);

    // The count must hold the capacity itself.
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CTL_W-1:0] CAP_E = CTL_W'(CAPACITY);

    // The sequencer either takes requests or walks the list for a dump.
    typedef enum logic [1:0] {
        S_RUN  = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    state_t             state_reg;
    state_t             state_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W-1:0]   dump_idx_reg;
    logic [CNT_W-1:0]   dump_idx_next;

    // Output register: it parts the request side from the result side.
    logic               out_valid_reg;
    logic [STAT_W-1:0]  status_reg;
    logic [DATA_W-1:0]  element_reg;
    logic [LEN_W-1:0]   length_reg;
    logic               last_reg;

    logic               load;
    status_t            res_status;
    logic [DATA_W-1:0]  res_element;
    logic [CTL_W-1:0]   res_count;
    logic               res_last;

    logic               out_free;
    logic               accept;
    logic [CTL_W-1:0]   cnt_e;
    logic [CTL_W-1:0]   ipos;
    logic [CTL_W-1:0]   dpos;

    cell_ctl_t          ctl;
    logic [DATA_W-1:0]  cell_data [CAPACITY];

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_RUN) || !out_free;
    assign accept   = in_valid && !in_stall;
    assign cnt_e    = CTL_W'(count_reg);

    // Insert and delete positions for the three forms of each operation.
    always_comb
    begin
        case (mode_t'(mode))
            MODE_INS_FRONT: ipos = '0;
            MODE_INS_END:   ipos = cnt_e;
            default:        ipos = CTL_W'(position);
        endcase
        case (mode_t'(mode))
            MODE_DEL_FRONT: dpos = '0;
            MODE_DEL_END:   dpos = cnt_e - CTL_W'(1);
            default:        dpos = CTL_W'(position);
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        dump_idx_next = dump_idx_reg;
        load          = 1'b0;
        res_status    = STAT_OK;
        res_element   = '0;
        res_count     = cnt_e;
        res_last      = 1'b1;
        ctl.op        = CELL_HOLD;
        ctl.pos       = '0;
        ctl.tail      = cnt_e - CTL_W'(1);
        ctl.value     = value;
        ctl.head      = cell_data[0];

        case (state_reg)
            S_RUN:
            begin
                if (accept)
                begin
                    load = 1'b1;
                    case (mode_t'(mode))
                        MODE_INS_FRONT, MODE_INS_END, MODE_INS_AT:
                        begin
                            // A bad position is reported ahead of a full list.
                            if (ipos > cnt_e)
                            begin
                                res_status = STAT_RANGE;
                            end
                            else if (cnt_e >= CAP_E)
                            begin
                                res_status = STAT_FULL;
                            end
                            else
                            begin
                                ctl.op     = CELL_INS;
                                ctl.pos    = ipos;
                                count_next = count_reg + CNT_W'(1);
                                res_count  = cnt_e + CTL_W'(1);
                            end
                        end
                        MODE_DEL_FRONT, MODE_DEL_END, MODE_DEL_AT:
                        begin
                            // An empty list is reported ahead of a bad position.
                            if (count_reg == '0)
                            begin
                                res_status = STAT_EMPTY;
                            end
                            else if (dpos >= cnt_e)
                            begin
                                res_status = STAT_RANGE;
                            end
                            else
                            begin
                                ctl.op     = CELL_DEL;
                                ctl.pos    = dpos;
                                count_next = count_reg - CNT_W'(1);
                                res_count  = cnt_e - CTL_W'(1);
                            end
                        end
                        MODE_DUMP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status = STAT_EMPTY;
                            end
                            else
                            begin
                                // The walk starts in the next cycle.
                                load          = 1'b0;
                                state_next    = S_DUMP;
                                dump_idx_next = '0;
                            end
                        end
                        default:
                        begin
                            res_status = STAT_OK;
                        end
                    endcase
                end
            end
            S_DUMP:
            begin
                if (out_free)
                begin
                    // Send the head and rotate the occupied cells by one; after
                    // count rotations the list is back in its original order.
                    load        = 1'b1;
                    res_element = cell_data[0];
                    res_last    = (dump_idx_reg == count_reg - CNT_W'(1));
                    ctl.op      = CELL_ROT;
                    dump_idx_next = dump_idx_reg + CNT_W'(1);
                    if (res_last)
                    begin
                        state_next = S_RUN;
                    end
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            count_reg     <= '0;
            dump_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            dump_idx_reg <= dump_idx_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg  <= res_status;
            element_reg <= res_element;
            length_reg  <= res_count[LEN_W-1:0];
            last_reg    <= res_last;
        end
    end

    // The chain: each cell sees its two neighbors. The first cell takes the request value on its left
    // and the last feeds itself on its right; what an end cell takes there is never read below the count.
    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        logic [DATA_W-1:0] left_in;
        logic [DATA_W-1:0] right_in;

        if (g == 0)
        begin : g_first
            assign left_in = value;
        end
        else
        begin : g_mid_l
            assign left_in = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_final
            assign right_in = cell_data[g];
        end
        else
        begin : g_mid_r
            assign right_in = cell_data[g+1];
        end

        olide_cell #(
            .IDX (g)
        ) u_cell (
            .clk        (clk),
            .ctl        (ctl),
            .left_data  (left_in),
            .right_data (right_in),
            .data       (cell_data[g])
        );
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign element   = element_reg;
    assign length    = length_reg;
    assign last      = last_reg;

endmodule

// ===== rtl/olide_checker.sv =====
`include "ordered_list_insert_delete_engine_unit_assert.svh"

module olide_checker
    import olide_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [STAT_W-1:0]   status,
    input  logic [DATA_W-1:0]   element,
    input  logic [LEN_W-1:0]    length,
    input  logic                last
);

    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    logic res_held;
    logic res_empty;

    assign res_held  = out_valid && out_stall;
    assign res_empty = out_valid && status == STAT_EMPTY;

    // A stalled result stays valid and holds still.
    `OLIDE_ASSERT_NEXT(a_out_hold, res_held, out_valid)
    `OLIDE_ASSERT_NEXT(a_out_data, res_held, $stable({status, element, length, last}))

    // A full report comes only from a list at capacity.
    `OLIDE_ASSERT_SAME(a_full_len, out_valid && status == STAT_FULL, length == CAP_LEN)

    // An empty report closes its request with nothing in the list.
    `OLIDE_ASSERT_SAME(a_empty_res, res_empty, last && element == '0 && length == '0)

    // Only a dump of a non-empty list gives more than one result.
    `OLIDE_ASSERT_SAME(a_multi_ok, out_valid && !last, status == STAT_OK)

endmodule

bind ordered_list_insert_delete_engine_unit olide_checker #(
    .CAPACITY (CAPACITY)
) u_olide_checker (.*);

// ===== test/ordered_list_insert_delete_engine_unit_tb.sv =====
`timescale 1ns / 1ps

module ordered_list_insert_delete_engine_unit_tb;

    import olide_pkg::*;

    // The list capacity the block is built with; the bench keeps its own copy of the list.
    localparam int LIST_CAP = CAPACITY_DEF;

    // Mode seven is not a list operation; the block must answer it with a plain ok.
    localparam logic [MODE_W-1:0] MODE_UNUSED = 3'd7;

    // Number of cycles after which the run is declared hung. The slowest correct run
    // (every request a full dump, every result held off by the receiver) stays far below.
    localparam int CYCLE_LIMIT = 400000;

    // Cycles to keep watching the result channel once nothing is expected any more.
    localparam int DRAIN_CYCLES = 10;

    // How many mismatches are printed in full before the rest are only counted.
    localparam int REPORT_LIMIT = 10;

    // One list request as it is presented on the request channel.
    typedef struct {
        logic [MODE_W-1:0]          mode;
        logic signed [DATA_W-1:0]   value;
        logic [POS_W-1:0]           position;
    } list_req_t;

    // One result as the block should deliver it.
    typedef struct {
        status_t                    status;
        logic signed [DATA_W-1:0]   element;
        logic [LEN_W-1:0]           length;
        logic                       last;
    } list_result_t;

    // Block ports. Every input starts at a known value.
    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [MODE_W-1:0]          mode = '0;
    logic signed [DATA_W-1:0]   value = '0;
    logic [POS_W-1:0]           position = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [STAT_W-1:0]          status;
    logic signed [DATA_W-1:0]   element;
    logic [LEN_W-1:0]           length;
    logic                       last;

    // Requests waiting to be driven, filled by the sequence below.
    list_req_t      pending_reqs[$];
    // Results the block owes, oldest first.
    list_result_t   owed_results[$];

    // The bench's own image of the list contents and its entry count.
    logic signed [DATA_W-1:0] list_words[LIST_CAP];
    int             list_len = 0;

    // Entry count as the request generator sees it, one step ahead of the block.
    // Directed requests leave the list empty, so it starts at zero and stays in step.
    int             plan_len = 0;
    // The generator sweeps the list between empty and full: it leans toward
    // inserts while growing and toward deletes while shrinking.
    bit             growing = 1'b1;

    int             reqs_queued = 0;
    int             reqs_accepted = 0;
    int             mismatch_count = 0;
    int             cycle_count = 0;

    // Idle rates in percent: how often the sender holds back a request and how
    // often the receiver stalls the result channel.
    int             send_idle_pct = 0;
    int             recv_stall_pct = 0;

    ordered_list_insert_delete_engine_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .mode       (mode),
        .value      (value),
        .position   (position),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .status     (status),
        .element    (element),
        .length     (length),
        .last       (last)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hang guard. A run that reaches the limit has lost a request or a result.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // List predictor. It mirrors the block's list and appends the results
    // that each accepted request must produce.
    // ------------------------------------------------------------------

    task automatic owe_result(input status_t st, input logic signed [DATA_W-1:0] word,
                              input int count, input logic is_last);
        list_result_t res;
        res.status  = st;
        res.element = word;
        // The length field is six bits wide, so a count of 64 would wrap to zero.
        res.length  = count[LEN_W-1:0];
        res.last    = is_last;
        owed_results.push_back(res);
    endtask

    // Insert before index at. A position past the end is reported before a full list,
    // and a position equal to the count appends.
    function automatic status_t list_insert(input int at, input logic signed [DATA_W-1:0] word);
        if (at > list_len)
            return STAT_RANGE;
        if (list_len >= LIST_CAP)
            return STAT_FULL;
        for (int i = list_len; i > at; i--)
            list_words[i] = list_words[i - 1];
        list_words[at] = word;
        list_len++;
        return STAT_OK;
    endfunction

    // Remove index at. An empty list is reported ahead of a bad position.
    function automatic status_t list_delete(input int at);
        if (list_len == 0)
            return STAT_EMPTY;
        if (at >= list_len)
            return STAT_RANGE;
        for (int i = at; i + 1 < list_len; i++)
            list_words[i] = list_words[i + 1];
        list_len--;
        return STAT_OK;
    endfunction

    task automatic predict_list_op(input list_req_t req);
        status_t st;
        st = STAT_OK;
        case (req.mode)
            MODE_INS_FRONT: st = list_insert(0, req.value);
            MODE_INS_END:   st = list_insert(list_len, req.value);
            MODE_INS_AT:    st = list_insert(int'(req.position), req.value);
            MODE_DEL_FRONT: st = list_delete(0);
            MODE_DEL_END:   st = (list_len == 0) ? STAT_EMPTY : list_delete(list_len - 1);
            MODE_DEL_AT:    st = list_delete(int'(req.position));
            MODE_DUMP:
            begin
                // A dump walks the list front to back, one result per entry; an
                // empty list still answers once, flagged empty.
                if (list_len == 0)
                    owe_result(STAT_EMPTY, '0, 0, 1'b1);
                for (int i = 0; i < list_len; i++)
                    owe_result(STAT_OK, list_words[i], list_len, i == list_len - 1);
                return;
            end
            default:        st = STAT_OK;
        endcase
        owe_result(st, '0, list_len, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // Request driver. A new request is offered only when the channel is free
    // (nothing shown, or the shown request taken at this edge); a stalled
    // request is held unchanged. Each signal gets one assignment per edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : drive_requests
        list_req_t req;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else if (!in_valid || !in_stall)
        begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                req = pending_reqs.pop_front();
                mode     <= req.mode;
                value    <= req.value;
                position <= req.position;
                in_valid <= 1'b1;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // The receiver stalls the result channel at random, at the rate of the current phase.
    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor. Both channels are sampled at the rising edge, so the values seen
    // are the ones the block saw. The result side is checked first: a result
    // taken at this edge can only come from a request taken at an earlier edge.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_channels
        list_result_t exp_res;
        list_req_t    req;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (owed_results.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("%0t: result with none owed: ", $time,
                                 "status %0d element %0d length %0d last %0d",
                                 status, element, length, last);
                end
                else
                begin
                    exp_res = owed_results.pop_front();
                    if (status !== exp_res.status || element !== exp_res.element ||
                        length !== exp_res.length || last !== exp_res.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_LIMIT)
                            $display("%0t: wrong result: ", $time,
                                     "expected status %0d element %0d length %0d last %0d, ",
                                     exp_res.status, exp_res.element, exp_res.length,
                                     exp_res.last,
                                     "got status %0d element %0d length %0d last %0d",
                                     status, element, length, last);
                    end
                end
            end
            if (in_valid && !in_stall)
            begin
                req.mode     = mode;
                req.value    = value;
                req.position = position;
                predict_list_op(req);
                reqs_accepted++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------

    task automatic queue_req(input logic [MODE_W-1:0] op, input logic signed [DATA_W-1:0] word,
                             input logic [POS_W-1:0] pos);
        list_req_t req;
        req.mode     = op;
        req.value    = word;
        req.position = pos;
        pending_reqs.push_back(req);
        reqs_queued++;
    endtask

    // Random requests. Most positions are legal for the list as it will stand, so
    // the list really moves between empty and full; the rest roam the whole
    // six-bit field to hit the out-of-range cases, including on a full list.
    task automatic queue_random_reqs(input int count);
        logic [MODE_W-1:0]        op;
        logic signed [DATA_W-1:0] word;
        logic [POS_W-1:0]         pos;
        int                       pick;
        int                       at;
        bit                       is_insert;
        for (int n = 0; n < count; n++)
        begin
            word = $urandom;
            if ($urandom_range(9) == 0)
            begin
                case ($urandom_range(3))
                    0: word = 32'sh8000_0000;
                    1: word = 32'sh7fff_ffff;
                    2: word = '0;
                    default: word = -1;
                endcase
            end
            pos  = POS_W'($urandom_range(63));
            pick = $urandom_range(99);
            is_insert = growing ? (pick < 78) : (pick < 35);
            if (pick < 10)
            begin
                op = MODE_DUMP;
            end
            else if (pick < 13)
            begin
                op = MODE_UNUSED;
            end
            else if (is_insert)
            begin
                op = MODE_W'(MODE_INS_FRONT + $urandom_range(2));
                if (op == MODE_INS_AT && $urandom_range(6) != 0)
                    pos = POS_W'($urandom_range(plan_len));
                at = (op == MODE_INS_FRONT) ? 0 : (op == MODE_INS_END) ? plan_len : int'(pos);
                if (at <= plan_len && plan_len < LIST_CAP)
                    plan_len++;
            end
            else
            begin
                op = MODE_W'(MODE_DEL_FRONT + $urandom_range(2));
                if (op == MODE_DEL_AT && plan_len > 0 && $urandom_range(6) != 0)
                    pos = POS_W'($urandom_range(plan_len - 1));
                at = (op == MODE_DEL_FRONT) ? 0 : (op == MODE_DEL_END) ? plan_len - 1 : int'(pos);
                if (plan_len > 0 && at < plan_len)
                    plan_len--;
            end
            // Linger a little at either end so full and empty get hammered.
            if (growing && plan_len == LIST_CAP && $urandom_range(3) == 0)
                growing = 1'b0;
            else if (!growing && plan_len == 0 && $urandom_range(3) == 0)
                growing = 1'b1;
            queue_req(op, word, pos);
        end
    endtask

    task automatic wait_all_taken();
        while (reqs_accepted < reqs_queued)
            @(posedge clk);
    endtask

    task automatic wait_results_drained();
        while (owed_results.size() != 0)
            @(posedge clk);
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Phase one: the sender idles now and then, the receiver stalls often.
        send_idle_pct  = 28;
        recv_stall_pct = 62;

        // Directed part. Every delete on an empty list must say empty, even with a
        // wild position; then the list is built with extreme words, probed out of
        // range, dumped, and emptied again.
        queue_req(MODE_DUMP,      '0,           '0);
        queue_req(MODE_DEL_FRONT, '0,           '0);
        queue_req(MODE_DEL_END,   -1,           6'd63);
        queue_req(MODE_DEL_AT,    '0,           6'd63);
        queue_req(MODE_INS_AT,    32'sd5,       6'd1);
        queue_req(MODE_INS_AT,    32'sd5,       6'd32);
        queue_req(MODE_INS_AT,    '0,           6'd0);
        queue_req(MODE_INS_FRONT, 32'sh8000_0000, '0);
        queue_req(MODE_INS_END,   32'sh7fff_ffff, 6'd63);
        queue_req(MODE_INS_AT,    -1,           6'd3);
        queue_req(MODE_INS_AT,    32'sh5555_5555, 6'd2);
        queue_req(MODE_INS_AT,    32'sh2aaa_aaaa, 6'd6);
        queue_req(MODE_DUMP,      -1,           6'd63);
        queue_req(MODE_DEL_AT,    '0,           6'd5);
        queue_req(MODE_DEL_AT,    '0,           6'd2);
        queue_req(MODE_UNUSED,    -1,           6'd63);
        queue_req(MODE_DEL_FRONT, '0,           '0);
        queue_req(MODE_DEL_END,   '0,           '0);
        queue_req(MODE_DUMP,      '0,           '0);
        queue_req(MODE_DEL_AT,    '0,           6'd1);
        queue_req(MODE_DEL_AT,    '0,           6'd0);
        queue_req(MODE_DEL_AT,    '0,           6'd0);
        queue_req(MODE_DUMP,      '0,           '0);
        wait_all_taken();

        // The sender holds off here until the block has answered everything.
        wait_results_drained();

        queue_random_reqs(130);
        wait_all_taken();

        // Phase two: the sender idles often, the receiver stalls now and then.
        send_idle_pct  = 62;
        recv_stall_pct = 28;
        queue_random_reqs(130);
        wait_all_taken();

        // Phase three: both sides run flat out.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_random_reqs(127);
        wait_all_taken();

        // Let the last dump finish, then keep watching for stray results.
        wait_results_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
